[hw/rtl/atfte_pkg.sv]
package atfte_pkg;

  localparam int BUF_W = 13;
  localparam logic [BUF_W-1:0] BUF_RESET = 13'd256;
  localparam int MAX_BUFFER_BYTES_DEF = 4096;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_TERM = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } result_t;

  // Results made from one input byte, handed to the output stage.
  typedef struct packed {
    logic    first;
    logic    second;
    result_t r0;
    result_t r1;
  } push_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] code;
  } sym_t;

  function automatic sym_t sym_lookup(input logic [7:0] c);
    sym_t s;
    s.hit = 1'b1;
    unique case (c)
      8'h20: s.code = 16'h8140; // space
      8'h21: s.code = 16'h8149; // !
      8'h22: s.code = 16'h8168; // "
      8'h23: s.code = 16'h8194; // #
      8'h24: s.code = 16'h8190; // $
      8'h25: s.code = 16'h8193; // %
      8'h26: s.code = 16'h8195; // &
      8'h28: s.code = 16'h8169; // (
      8'h29: s.code = 16'h816A; // )
      8'h5B: s.code = 16'h816D; // [
      8'h5D: s.code = 16'h816E; // ]
      8'h2A: s.code = 16'h8196; // *
      8'h2B: s.code = 16'h817B; // +
      8'h27: s.code = 16'h8166; // '
      8'h2C: s.code = 16'h8143; // ,
      8'h2D: s.code = 16'h817C; // -
      8'h2F: s.code = 16'h815E; // /
      8'h3A: s.code = 16'h8146; // :
      8'h3B: s.code = 16'h8147; // ;
      8'h3D: s.code = 16'h8181; // =
      8'h3F: s.code = 16'h8148; // ?
      8'h40: s.code = 16'h8197; // @
      8'h5F: s.code = 16'h8151; // _
      default: begin
        s.hit  = 1'b0;
        s.code = 16'h0000;
      end
    endcase
    return s;
  endfunction

endpackage

[hw/rtl/atfte_core.sv]
module atfte_core #(
  parameter int MAX_BUFFER_BYTES = atfte_pkg::MAX_BUFFER_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_char,
  input  logic                       buffer_bytes_we,
  input  logic [atfte_pkg::BUF_W-1:0] buffer_bytes,
  input  logic                       room,
  output atfte_pkg::push_t           push
);
  import atfte_pkg::*;

  localparam int CNT_W  = $clog2(MAX_BUFFER_BYTES);
  localparam int LIM_W0 = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int LW     = ((LIM_W0 > BUF_W) ? LIM_W0 : BUF_W) + 1;

  logic [BUF_W-1:0] buf_size;
  logic [7:0]       char_q;
  logic             char_valid;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             failed;
  logic             failed_next;
  logic             process;
  logic [LW-1:0]    limit;
  logic [LW-1:0]    size_ext;
  logic             is_alnum;
  sym_t             sym;
  logic             two_byte;

  assign process  = char_valid && room;
  assign in_stall = char_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_size   <= BUF_RESET;
      char_valid <= 1'b0;
      count      <= '0;
      failed     <= 1'b0;
    end else begin
      if (buffer_bytes_we) begin
        buf_size <= buffer_bytes;
      end
      if (in_valid && !in_stall) begin
        char_q     <= in_char;
        char_valid <= 1'b1;
      end else if (process) begin
        char_valid <= 1'b0;
      end
      if (process) begin
        count  <= count_next;
        failed <= failed_next;
      end
    end
  end

  assign size_ext = LW'(buf_size);
  assign limit = (size_ext > LW'(MAX_BUFFER_BYTES)) ? LW'(MAX_BUFFER_BYTES) : size_ext;

  assign is_alnum = (char_q >= "0" && char_q <= "9") || (char_q >= "A" && char_q <= "Z") ||
                    (char_q >= "a" && char_q <= "z");
  assign sym      = sym_lookup(char_q);
  assign two_byte = sym.hit && !is_alnum;

  always_comb begin
    push        = '0;
    count_next  = count;
    failed_next = failed;
    if (char_q == CHAR_NUL) begin
      count_next  = '0;
      failed_next = 1'b0;
      if (!failed) begin
        push.first     = 1'b1;
        push.r0.status = ST_TERM;
        push.r0.last   = 1'b1;
      end
    end else if (!failed && char_q != CHAR_NEWLINE) begin
      if (two_byte) begin
        if (LW'(count) + LW'(3) >= limit) begin
          failed_next    = 1'b1;
          push.first     = 1'b1;
          push.r0.status = ST_OVF;
          push.r0.last   = 1'b1;
        end else begin
          push.first   = 1'b1;
          push.second  = 1'b1;
          push.r0.data = sym.code[15:8];
          push.r1.data = sym.code[7:0];
          count_next   = count + CNT_W'(2);
        end
      end else begin
        if (LW'(count) + LW'(2) >= limit) begin
          failed_next    = 1'b1;
          push.first     = 1'b1;
          push.r0.status = ST_OVF;
          push.r0.last   = 1'b1;
        end else begin
          push.first   = 1'b1;
          push.r0.data = char_q;
          count_next   = count + CNT_W'(1);
        end
      end
    end
    if (!process) begin
      push.first  = 1'b0;
      push.second = 1'b0;
    end
  end

endmodule

[hw/rtl/atfte_out.sv]
module atfte_out (
  input  logic             clk,
  input  logic             rst,
  input  atfte_pkg::push_t push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_status,
  output logic             out_last
);
  import atfte_pkg::*;

  result_t out_q;
  result_t pend_q;
  logic    pend_valid;
  logic    out_take;

  assign out_take = out_valid && !out_stall;
  // A new pair goes in only when the second-byte slot is free and the output frees up now.
  assign room = !pend_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (push.first) begin
        out_q      <= push.r0;
        out_valid  <= 1'b1;
        pend_q     <= push.r1;
        pend_valid <= push.second;
      end else if (pend_valid && (out_take || !out_valid)) begin
        out_q      <= pend_q;
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_byte   = out_q.data;
  assign out_status = out_q.status;
  assign out_last   = out_q.last;

endmodule

[hw/rtl/ascii_to_fullwidth_text_encoder_unit.sv]
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_char
// out      output     out_valid / out_stall out_byte, out_status, out_last
// cfg      input      buffer_bytes_we      buffer_bytes
//
// An input byte is held in an input register and encoded into the output register once the
// output has room, so each result passes through the input register and then the output
// register before it transfers out.
// The output register sends one byte per cycle while out_stall is low; a plain input byte
// gives one byte and a full-width symbol two, whose low byte waits in a second-byte register.
// rst is synchronous; it clears the count, the overflow flag, all three valid bits and sets the
// buffer size to 256. A stall on the output backs up into in_stall once the input holds a byte.
module ascii_to_fullwidth_text_encoder_unit #(
  parameter int MAX_BUFFER_BYTES = atfte_pkg::MAX_BUFFER_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_char,
  input  logic                        buffer_bytes_we,
  input  logic [atfte_pkg::BUF_W-1:0] buffer_bytes,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic [1:0]                  out_status,
  output logic                        out_last
);
  import atfte_pkg::*;

  push_t push;
  logic  room;

  atfte_core #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char        (in_char),
    .buffer_bytes_we(buffer_bytes_we),
    .buffer_bytes   (buffer_bytes),
    .room           (room),
    .push           (push)
  );

  atfte_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_status(out_status),
    .out_last  (out_last)
  );

`ifndef SYNTH
  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == ST_DATA || out_status == ST_TERM || out_status == ST_OVF))
    else $error("undefined status code");

  a_last_matches_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_status != ST_DATA)))
    else $error("last flag does not match status");

  a_end_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_DATA) |-> (out_byte == 8'h00))
    else $error("nonzero byte on terminator or overflow");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import atfte_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int SYM_N = 23;

  // Symbol characters and their full-width codes, entry k at bits [k*8] and [k*16].
  localparam logic [SYM_N*8-1:0] FW_CHARS = {
    8'h5F, 8'h40, 8'h3F, 8'h3D, 8'h3B, 8'h3A, 8'h2F, 8'h2D, 8'h2C, 8'h27, 8'h2B, 8'h2A,
    8'h5D, 8'h5B, 8'h29, 8'h28, 8'h26, 8'h25, 8'h24, 8'h23, 8'h22, 8'h21, 8'h20
  };
  localparam logic [SYM_N*16-1:0] FW_CODES = {
    16'h8151, 16'h8197, 16'h8148, 16'h8181, 16'h8147, 16'h8146, 16'h815E, 16'h817C,
    16'h8143, 16'h8166, 16'h817B, 16'h8196, 16'h816E, 16'h816D, 16'h816A, 16'h8169,
    16'h8195, 16'h8193, 16'h8190, 16'h8194, 16'h8168, 16'h8149, 16'h8140
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_char = CHAR_NUL;
  logic buffer_bytes_we = 1'b0;
  logic [BUF_W-1:0] buffer_bytes = BUF_RESET;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] out_status;
  logic out_last;

  // Shadow of the encoder state.
  logic [BUF_W-1:0] size_shadow = BUF_RESET;
  int unsigned written_count = 0;
  bit overflowed = 1'b0;
  result_t pending_results[$];

  int errors = 0;
  int idle_cycles = 0;
  int chars_sent = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  ascii_to_fullwidth_text_encoder_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char(in_char),
    .buffer_bytes_we(buffer_bytes_we),
    .buffer_bytes(buffer_bytes),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .out_status(out_status),
    .out_last(out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void queue_result(input logic [7:0] d, input logic [1:0] s,
                                       input logic l);
    result_t r;
    r.data = d;
    r.status = s;
    r.last = l;
    pending_results.push_back(r);
  endfunction

  function automatic void encode_predict(input logic [7:0] c);
    int unsigned cap;
    int k;
    logic hit;
    logic [15:0] code;
    cap = (size_shadow > MAX_BUFFER_BYTES_DEF) ? MAX_BUFFER_BYTES_DEF : size_shadow;
    hit = 1'b0;
    code = 16'h0000;
    for (k = 0; k < SYM_N; k++) begin
      if (FW_CHARS[k*8 +: 8] == c) begin
        hit = 1'b1;
        code = FW_CODES[k*16 +: 16];
      end
    end
    if (c == CHAR_NUL) begin
      // A string that overflowed already sent its last result.
      if (!overflowed) queue_result(CHAR_NUL, ST_TERM, 1'b1);
      written_count = 0;
      overflowed = 1'b0;
    end else if (!overflowed && c != CHAR_NEWLINE) begin
      // One byte is always held back for the terminator.
      if (written_count + (hit ? 3 : 2) >= cap) begin
        overflowed = 1'b1;
        queue_result(CHAR_NUL, ST_OVF, 1'b1);
      end else if (hit) begin
        queue_result(code[15:8], ST_DATA, 1'b0);
        queue_result(code[7:0], ST_DATA, 1'b0);
        written_count += 2;
      end else begin
        queue_result(c, ST_DATA, 1'b0);
        written_count += 1;
      end
    end
  endfunction

  function automatic logic [7:0] random_char();
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 61);
    if (pick < 35) begin
      if (sel < 10) return 8'("0" + sel);
      else if (sel < 36) return 8'("A" + sel - 10);
      else return 8'("a" + sel - 36);
    end else if (pick < 65) begin
      return FW_CHARS[$urandom_range(0, SYM_N-1)*8 +: 8];
    end else if (pick < 72) begin
      return CHAR_NEWLINE;
    end
    return 8'($urandom_range(1, 255));
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result byte=%h status=%0d last=%0d",
                 $time, out_byte, out_status, out_last);
      end else begin
        want = pending_results.pop_front();
        if (out_byte !== want.data) begin
          errors++;
          $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte);
        end
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: out_status expected %0d actual %0d", $time, want.status,
                   out_status);
        end
        if (out_last !== want.last) begin
          errors++;
          $display("%0t: out_last expected %0d actual %0d", $time, want.last, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= out_idle_on && ($urandom_range(0, 99) < 10);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("ascii_to_fullwidth_text_encoder_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Starts and returns at a rising edge; valid stays high unless a gap is taken.
  task automatic send_char(input logic [7:0] c);
    in_valid <= 1'b1;
    in_char <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_predict(c);
    chars_sent++;
    if (in_idle_on && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      in_char <= 8'($urandom);
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Dropped bytes leave no result, so give the pipeline time to empty.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_buffer_size(input logic [BUF_W-1:0] value);
    wait_for_results();
    buffer_bytes_we <= 1'b1;
    buffer_bytes <= value;
    @(posedge clk);
    buffer_bytes_we <= 1'b0;
    size_shadow = value;
  endtask

  task automatic send_string(input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) send_char(random_char());
    if ($urandom_range(0, 49) == 0) wait_for_results();
    send_char(CHAR_NUL);
  endtask

  task automatic test_plain_and_symbols();
    send_char("A");
    send_char("z");
    send_char("0");
    send_char("9");
    send_char(".");
    send_char(8'h80);
    send_char(8'hFF);
    send_char(8'h01);
    send_char(CHAR_NEWLINE);
    send_char(" ");
    send_char("_");
    send_char("@");
    send_char("'");
    send_char(CHAR_NUL);
    // An empty string still gets its terminator.
    send_char(CHAR_NUL);
  endtask

  task automatic test_overflow_edges();
    write_buffer_size(13'd2);
    send_char("a");
    send_char("b");
    send_char("#");
    send_char(CHAR_NUL);
    send_char(CHAR_NUL);
    write_buffer_size(13'd4);
    send_char("x");
    send_char("y");
    send_char(CHAR_NUL);
    write_buffer_size(13'd5);
    send_char("!");
    send_char("a");
    send_char(CHAR_NUL);
  endtask

  task automatic test_size_sweep();
    logic [BUF_W-1:0] sizes [12];
    int unsigned cap;
    int phase;
    int stop_at;
    sizes = '{13'd3, 13'd6, 13'd9, 13'd17, 13'd0, 13'd1, 13'd8191, 13'd4097, 13'd4096,
              13'd2, 13'd12, 13'd0};
    sizes[11] = 13'($urandom_range(2, 40));
    for (phase = 0; phase < 12; phase++) begin
      write_buffer_size(sizes[phase]);
      cap = (sizes[phase] > MAX_BUFFER_BYTES_DEF) ? MAX_BUFFER_BYTES_DEF : sizes[phase];
      stop_at = chars_sent + 80;
      // Small buffers get strings long enough to overflow; large ones stay short.
      while (chars_sent < stop_at)
        send_string($urandom_range(0, (cap < 24) ? cap + 3 : 12));
    end
  endtask

  task automatic test_back_to_back();
    int stop_at;
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    write_buffer_size(13'd20);
    stop_at = chars_sent + 60;
    while (chars_sent < stop_at) send_string($urandom_range(0, 23));
    wait_for_results();
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_plain_and_symbols();
    test_overflow_edges();
    test_back_to_back();
    test_size_sweep();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("ascii_to_fullwidth_text_encoder_unit: match");
    else
      $display("ascii_to_fullwidth_text_encoder_unit: mismatch");
    $finish;
  end

endmodule
